>>> sv/top_k_index_selector_defines.svh
// assertion macros for the top-k index selector checker
// needs clk and rst_n in the scope of each use
`ifndef TOP_K_INDEX_SELECTOR_DEFINES_SVH
`define TOP_K_INDEX_SELECTOR_DEFINES_SVH

// same-cycle implication
`define TKS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("top_k_index_selector check failed");

// next-cycle implication
`define TKS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("top_k_index_selector check failed");

`endif

>>> sv/tks_pkg.sv
// shared types and constants of the top-k index selector
// no dependencies
`default_nettype none

package tks_pkg;

  localparam int KEY_BITS        = 20;
  localparam int IDX_BITS        = 6;
  localparam int CNT_BITS        = 7;
  localparam int RESULT_CAP      = 64;
  localparam int RESET_MAX_COUNT = 20;

  localparam logic [KEY_BITS-1:0] KEY_REMOVED = '1;

  typedef struct packed {
    logic signed [KEY_BITS-1:0] sort_key;
    logic                       last_key;
  } tks_in_t;

  typedef struct packed {
    logic [IDX_BITS-1:0]        entry_index;
    logic signed [KEY_BITS-1:0] entry_key;
    logic                       found;
    logic                       run_end;
  } tks_out_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_WAIT,
    ST_PICK,
    ST_FLUSH,
    ST_EMPTY
  } tks_state_t;

  typedef struct packed {
    logic load;
    logic run_start;
    logic rd;
    logic pick;
    logic flush;
    logic empty;
  } tks_cmd_t;

  typedef struct packed {
    logic limit_zero;
    logic limit_hit;
    logic scan_last;
    logic any;
    logic hold_vld;
    logic out_free;
  } tks_sts_t;

endpackage

`default_nettype wire

>>> sv/tks_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module tks_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> sv/tks_ctrl.sv
// control state machine of the top-k index selector
// depends on tks_pkg
`default_nettype none

module tks_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  input  tks_pkg::tks_sts_t sts,
  output tks_pkg::tks_cmd_t cmd
);

  import tks_pkg::*;

  tks_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            cmd.run_start = 1'b1;
            state_nxt = sts.limit_zero ? ST_EMPTY : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.rd = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_nxt = ST_PICK;
      end
      ST_PICK: begin
        if (sts.any) begin
          if (!sts.hold_vld || sts.out_free) begin
            cmd.pick = 1'b1;
            state_nxt = sts.limit_hit ? ST_FLUSH : ST_SCAN;
          end
        end else begin
          state_nxt = sts.hold_vld ? ST_FLUSH : ST_EMPTY;
        end
      end
      ST_FLUSH: begin
        if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      ST_EMPTY: begin
        if (sts.out_free) begin
          cmd.empty = 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/tks_datapath.sv
// key store, maximum scan, held pick and output register
// depends on tks_pkg and tks_ram
`default_nettype none

module tks_datapath #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic [tks_pkg::CNT_BITS-1:0]   cfg_data,
  input  tks_pkg::tks_in_t               in_data,
  input  tks_pkg::tks_cmd_t              cmd,
  output tks_pkg::tks_sts_t              sts,
  output logic                           out_valid,
  input  logic                           out_ready,
  output tks_pkg::tks_out_t              out_data
);

  import tks_pkg::*;

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  logic [CNT_BITS-1:0]        max_count_r;
  logic [CW-1:0]              cnt_r;
  logic [AW-1:0]              scan_r;
  logic                       rd_vld_r;
  logic [AW-1:0]              rd_idx_r;
  logic                       best_any_r;
  logic [AW-1:0]              best_idx_r;
  logic signed [KEY_BITS-1:0] best_key_r;
  logic                       hold_vld_r;
  logic [AW-1:0]              hold_idx_r;
  logic signed [KEY_BITS-1:0] hold_key_r;
  logic [CNT_BITS-1:0]        done_r;
  logic                       out_vld_r;
  tks_out_t                   out_r;

  logic                       cnt_full;
  logic [CNT_BITS-1:0]        limit;
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [KEY_BITS-1:0]        ram_wdata;
  logic [KEY_BITS-1:0]        rd_key;
  logic                       take_best;
  logic                       scan_reset;
  logic                       out_free;
  logic                       out_load;

  assign cnt_full   = (cnt_r == CW'(MAX_ENTRIES));
  assign limit      = (max_count_r > CNT_BITS'(RESULT_CAP)) ? CNT_BITS'(RESULT_CAP)
                                                             : max_count_r;
  assign ram_we     = (cmd.load && !cnt_full) || cmd.pick;
  assign ram_waddr  = cmd.pick ? best_idx_r : cnt_r[AW-1:0];
  assign ram_wdata  = cmd.pick ? KEY_REMOVED : in_data.sort_key;
  assign take_best  = rd_vld_r && ($signed(rd_key) >= best_key_r);
  assign scan_reset = cmd.run_start || cmd.pick;
  assign out_free   = !out_vld_r || out_ready;
  assign out_load   = (cmd.pick && hold_vld_r) || cmd.flush || cmd.empty;

  assign sts.limit_zero = (max_count_r == '0);
  assign sts.limit_hit  = ((done_r + CNT_BITS'(1)) == limit);
  assign sts.scan_last  = (CW'(scan_r) == (cnt_r - CW'(1)));
  assign sts.any        = best_any_r;
  assign sts.hold_vld   = hold_vld_r;
  assign sts.out_free   = out_free;

  tks_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (MAX_ENTRIES)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (scan_r),
    .rdata (rd_key)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_count_r <= CNT_BITS'(RESET_MAX_COUNT);
      cnt_r       <= '0;
      scan_r      <= '0;
      rd_vld_r    <= 1'b0;
      best_any_r  <= 1'b0;
      hold_vld_r  <= 1'b0;
      done_r      <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        max_count_r <= cfg_data;
      end
      if (cmd.flush || cmd.empty) begin
        cnt_r <= '0;
      end else if (cmd.load && !cnt_full) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (scan_reset) begin
        scan_r <= '0;
      end else if (cmd.rd) begin
        scan_r <= scan_r + AW'(1);
      end
      rd_vld_r <= cmd.rd;
      if (scan_reset) begin
        best_any_r <= 1'b0;
      end else if (take_best) begin
        best_any_r <= 1'b1;
      end
      if (cmd.run_start) begin
        hold_vld_r <= 1'b0;
        done_r     <= '0;
      end else if (cmd.pick) begin
        hold_vld_r <= 1'b1;
        done_r     <= done_r + CNT_BITS'(1);
      end
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    rd_idx_r <= scan_r;
    if (scan_reset) begin
      best_idx_r <= '0;
      best_key_r <= '0;
    end else if (take_best) begin
      best_idx_r <= rd_idx_r;
      best_key_r <= $signed(rd_key);
    end
    if (cmd.pick) begin
      hold_idx_r <= best_idx_r;
      hold_key_r <= best_key_r;
    end
    if (cmd.empty) begin
      out_r.entry_index <= '0;
      out_r.entry_key   <= '0;
      out_r.found       <= 1'b0;
      out_r.run_end     <= 1'b1;
    end else if (out_load) begin
      out_r.entry_index <= IDX_BITS'(hold_idx_r);
      out_r.entry_key   <= hold_key_r;
      out_r.found       <= 1'b1;
      out_r.run_end     <= cmd.flush;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

>>> sv/top_k_index_selector.sv
// top level of the top-k index selector
// depends on tks_pkg, tks_ctrl, tks_datapath and tks_ram
//
// usage:
//   in_*  : one signed key per beat, stored at its load position; keys beyond
//           MAX_ENTRIES are dropped. a beat with last_key set starts selection.
//   out_* : one beat per picked entry in descending key order (higher index on
//           ties), run_end on the last one; an empty run gives one beat with
//           found low and run_end high.
//   cfg_* : writes max_count (entries per run, capped at 64); always ready.
// flow:
//   loading accepts one key per cycle. each pick then scans the n loaded keys
//   through the single read port of the key memory, and the final beat is
//   registered in the flush or empty state after the last search ends.
//   in_ready is low from the last key until the final result sits in the
//   output register.
// reset: count of loaded keys cleared, max_count 20, output empty; the key
//   memory is not cleared.
// stall: the output register holds its beat; the block waits before it would
//   overwrite it; loading of the next set starts once the final beat is stored.
`default_nettype none

module top_k_index_selector #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  tks_pkg::tks_in_t             in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output tks_pkg::tks_out_t            out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tks_pkg::CNT_BITS-1:0] cfg_data
);

  import tks_pkg::*;

  tks_cmd_t cmd;
  tks_sts_t sts;

  assign cfg_ready = 1'b1;

  tks_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_key),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tks_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> sv/tks_checker.sv
// port-level assertions for the top-k index selector, bound to its top level
// depends on tks_pkg and top_k_index_selector_defines.svh
`default_nettype none
`include "top_k_index_selector_defines.svh"

module tks_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire tks_pkg::tks_in_t             in_data,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire tks_pkg::tks_out_t            out_data,
  input wire logic                         cfg_valid,
  input wire logic                         cfg_ready,
  input wire logic [tks_pkg::CNT_BITS-1:0] cfg_data
);

  import tks_pkg::*;

  // stalled result beat holds
  `TKS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // empty-run marker is all zero and ends the run
  `TKS_ASSERT_IMP(a_empty_marker, out_valid && !out_data.found, out_data.run_end && (out_data.entry_index == '0) && (out_data.entry_key == '0))

  // a last key stops loading until the run is done
  `TKS_ASSERT_NXT(a_run_blocks_in, in_valid && in_ready && in_data.last_key, !in_ready)

  // picked keys are never absent entries
  `TKS_ASSERT_IMP(a_found_nonneg, out_valid && out_data.found, !out_data.entry_key[KEY_BITS-1])

endmodule

bind top_k_index_selector tks_checker u_tks_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_data  (cfg_data)
);

`default_nettype wire

>>> dv/tb_top_k_index_selector.sv
`timescale 1ns / 100ps
// self-checking testbench for top_k_index_selector: key sets in, picked entries out
// depends on tks_pkg and the top_k_index_selector rtl

module tb_top_k_index_selector;
  import tks_pkg::*;

  localparam int MAX_ENTRIES = 64;
  localparam int HOLD_CYCLES = 400;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  tks_in_t             in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  tks_out_t            out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CNT_BITS-1:0] cfg_data = '0;

  top_k_index_selector #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  tks_in_t  key_beats[$];
  tks_out_t expected_picks[$];
  int       bad_beats = 0;
  int       send_idle = 0;
  int       recv_idle = 0;
  logic     in_took = 1'b0;
  logic     hold_req = 1'b0;
  logic     hold_used = 1'b0;
  int       hold_cnt = 0;

  // predictor state
  logic signed [KEY_BITS-1:0] key_mem [MAX_ENTRIES];
  int unsigned                loaded_keys = 0;
  logic [CNT_BITS-1:0]        pick_limit = CNT_BITS'(RESET_MAX_COUNT);

  task automatic pick_expected(input tks_in_t beat);
    tks_out_t                   run [RESULT_CAP];
    int unsigned                lim;
    int unsigned                done;
    int unsigned                best;
    logic                       any;
    logic signed [KEY_BITS-1:0] high;
    if (loaded_keys < MAX_ENTRIES) begin
      key_mem[loaded_keys] = beat.sort_key;
      loaded_keys++;
    end
    if (!beat.last_key) return;
    lim  = (pick_limit > RESULT_CAP) ? RESULT_CAP : pick_limit;
    done = 0;
    while (done < lim) begin
      any  = 1'b0;
      best = 0;
      high = '0;
      for (int i = 0; i < loaded_keys; i++) begin
        if (key_mem[i] >= high) begin
          any  = 1'b1;
          best = i;
          high = key_mem[i];
        end
      end
      if (!any) break;
      run[done].entry_index = best[IDX_BITS-1:0];
      run[done].entry_key   = high;
      run[done].found       = 1'b1;
      run[done].run_end     = 1'b0;
      key_mem[best] = KEY_REMOVED;
      done++;
    end
    loaded_keys = 0;
    if (done == 0) begin
      expected_picks.push_back('{entry_index: '0, entry_key: '0, found: 1'b0, run_end: 1'b1});
    end else begin
      run[done-1].run_end = 1'b1;
      for (int k = 0; k < done; k++) expected_picks.push_back(run[k]);
    end
  endtask

  // monitor and checker
  always @(posedge clk) begin
    tks_out_t want;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (cfg_valid && cfg_ready) pick_limit = cfg_data;
      if (in_valid && in_ready) pick_expected(in_data);
      if (out_valid && out_ready) begin
        if (expected_picks.size() == 0) begin
          bad_beats++;
          if (bad_beats <= 10)
            $display("unexpected beat: index %0d key %0d found %0b end %0b",
                     out_data.entry_index, out_data.entry_key, out_data.found,
                     out_data.run_end);
        end else begin
          want = expected_picks.pop_front();
          if (out_data.entry_index !== want.entry_index ||
              out_data.entry_key !== want.entry_key ||
              out_data.found !== want.found ||
              out_data.run_end !== want.run_end) begin
            bad_beats++;
            if (bad_beats <= 10) begin
              $display("mismatch: expected index %0d key %0d found %0b end %0b,",
                       want.entry_index, want.entry_key, want.found, want.run_end);
              $display("  got index %0d key %0d found %0b end %0b",
                       out_data.entry_index, out_data.entry_key, out_data.found,
                       out_data.run_end);
            end
          end
        end
      end
    end
  end

  // key driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (key_beats.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
        in_data  <= key_beats.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      hold_cnt <= 0;
    end else if (hold_req && !hold_used) begin
      hold_cnt  <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= recv_idle);
    end
  end

  function automatic logic signed [KEY_BITS-1:0] rand_key(input int absent_pct);
    logic signed [KEY_BITS-1:0] k;
    k = KEY_BITS'($urandom);
    if ($urandom_range(0, 99) < absent_pct) begin
      k[KEY_BITS-1] = 1'b1;
    end else begin
      case ($urandom_range(0, 5))
        0:       k = KEY_BITS'($urandom_range(0, 3));
        1:       k = {1'b0, {(KEY_BITS-1){1'b1}}};
        2:       k = '0;
        default: k[KEY_BITS-1] = 1'b0;
      endcase
    end
    return k;
  endfunction

  task automatic add_beat(input logic signed [KEY_BITS-1:0] key, input logic last);
    key_beats.push_back('{sort_key: key, last_key: last});
  endtask

  task automatic queue_set(input int len, input int absent_pct);
    for (int i = 0; i < len; i++) add_beat(rand_key(absent_pct), i == len - 1);
  endtask

  task automatic write_max_count(input logic [CNT_BITS-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (key_beats.size() != 0 || in_valid || expected_picks.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    logic [CNT_BITS-1:0] limits [6];
    int                  queued;
    int                  len;
    limits = '{7'd127, 7'd5, 7'd64, 7'd65, 7'd3, 7'd0};
    limits[5] = CNT_BITS'($urandom_range(0, 64));
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed sets at the reset count, then at max_count 0, 1 and 2
    add_beat(20'sd524287, 1'b0);
    add_beat(-20'sd524288, 1'b0);
    add_beat(20'sd0, 1'b0);
    add_beat(20'sd0, 1'b0);
    add_beat(-20'sd1, 1'b0);
    add_beat(20'sd7, 1'b1);
    add_beat(-20'sd5, 1'b1);
    add_beat(20'sd3, 1'b0);
    add_beat(20'sd3, 1'b0);
    add_beat(20'sd3, 1'b1);
    wait_idle();
    write_max_count('0);
    add_beat(20'sd10, 1'b0);
    add_beat(20'sd20, 1'b1);
    wait_idle();
    write_max_count(7'd1);
    add_beat(20'sd1, 1'b0);
    add_beat(20'sd9, 1'b0);
    add_beat(20'sd9, 1'b1);
    wait_idle();
    write_max_count(7'd2);
    add_beat(-20'sd1, 1'b0);
    add_beat(20'sd0, 1'b1);
    wait_idle();

    for (int sub = 0; sub < 6; sub++) begin
      case (sub / 2)
        0: begin
          send_idle = 34;
          recv_idle = 52;
        end
        1: begin
          send_idle = 52;
          recv_idle = 34;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      write_max_count(limits[sub]);
      if (sub == 2) hold_req = 1'b1;
      queued = 0;
      // overflowing set, nearly all keys present
      if (sub == 0 || sub == 4) begin
        len = $urandom_range(65, 70);
        queue_set(len, 3);
        queued += len;
      end
      while (queued < 10) begin
        len = $urandom_range(1, 10);
        queue_set(len, 30);
        queued += len;
      end
      wait_idle();
    end

    if (bad_beats == 0 && expected_picks.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/tks_pkg.sv
sv/tks_ram.sv
sv/tks_ctrl.sv
sv/tks_datapath.sv
sv/top_k_index_selector.sv
sv/tks_checker.sv
dv/tb_top_k_index_selector.sv
